// ===== src/qsp_pkg.sv =====
package qsp_pkg;

    // Request kinds. The unused code is a no-op that reports the queue unchanged.
    typedef enum logic [1:0] {
        KIND_TAIL   = 2'd0,
        KIND_SECOND = 2'd1,
        KIND_POP    = 2'd2
    } t_kind;

endpackage

// ===== src/qsp_store.sv =====
module qsp_store #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 16,
    parameter int AW    = 4
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/queue_with_second_place_insert_unit.sv =====
// A result is registered in the cycle after its request is accepted, but a pop that
// leaves items behind passes through ST_POP_READ first, and a second-place insert
// into a non-empty queue through ST_INS_WRITE. One request per cycle (unless a result
// is held by i_rsp_stall) for tail pushes, drops, no-ops and pops that find or leave
// the queue empty; those two stall intake (store read latency, single store write port).
// Reset (synchronous, active low) empties the queue; store contents stay undefined.
module queue_with_second_place_insert_unit
    import qsp_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int HANDLE_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_req_valid,
    output logic                               o_req_stall,
    input  logic [1:0]                         i_req_kind,
    input  logic [HANDLE_BITS-1:0]             i_req_handle,
    output logic                               o_rsp_valid,
    input  logic                               i_rsp_stall,
    output logic                               o_rsp_popped_valid,
    output logic [HANDLE_BITS-1:0]             o_rsp_popped_handle,
    output logic                               o_rsp_front_valid,
    output logic [HANDLE_BITS-1:0]             o_rsp_front_handle,
    output logic                               o_rsp_is_empty,
    output logic [$clog2(QUEUE_DEPTH + 1)-1:0] o_rsp_occupancy,
    output logic                               o_rsp_dropped
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = AW + 2;
    localparam logic [AW-1:0] LAST_IDX   = AW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);
    localparam logic [SW-1:0] DEPTH_S    = SW'(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP_READ,
        ST_INS_WRITE
    } t_state;

    t_state                 r_state;
    logic [AW-1:0]          r_front;
    logic [CW-1:0]          r_count;
    logic [HANDLE_BITS-1:0] r_front_handle;
    logic [AW-1:0]          r_ins_addr;
    logic [HANDLE_BITS-1:0] r_ins_handle;

    logic                   r_rsp_valid;
    logic                   r_rsp_popped_valid;
    logic [HANDLE_BITS-1:0] r_rsp_popped_handle;
    logic                   r_rsp_front_valid;
    logic [HANDLE_BITS-1:0] r_rsp_front_handle;
    logic                   r_rsp_is_empty;
    logic [CW-1:0]          r_rsp_occupancy;
    logic                   r_rsp_dropped;

    t_kind                  req_kind;
    logic                   accept;
    logic                   is_full;
    logic                   is_empty;
    logic [SW-1:0]          tail_sum;
    logic [AW-1:0]          tail_idx;
    logic [AW-1:0]          front_inc;
    logic [AW-1:0]          front_dec;

    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [HANDLE_BITS-1:0] mem_wdata;
    logic [HANDLE_BITS-1:0] mem_rdata;

    assign req_kind    = t_kind'(i_req_kind);
    assign o_req_stall = (r_state != ST_IDLE) || (r_rsp_valid && i_rsp_stall);
    assign accept      = i_req_valid && !o_req_stall;
    assign is_full     = (r_count == FULL_COUNT);
    assign is_empty    = (r_count == '0);

    // The tail slot is front plus count, wrapped once around the ring.
    assign tail_sum  = SW'(r_front) + SW'(r_count);
    assign tail_idx  = (tail_sum >= DEPTH_S) ? AW'(tail_sum - DEPTH_S) : AW'(tail_sum);
    assign front_inc = (r_front == LAST_IDX) ? '0 : r_front + AW'(1);
    assign front_dec = (r_front == '0) ? LAST_IDX : r_front - AW'(1);

    // A second-place insert writes the old front into the slot ahead of it first,
    // then the new handle into the old front slot on the following cycle.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = tail_idx;
        mem_wdata = i_req_handle;
        if (r_state == ST_INS_WRITE) begin
            mem_we    = 1'b1;
            mem_waddr = r_ins_addr;
            mem_wdata = r_ins_handle;
        end else if (accept && !is_full &&
                     (req_kind == KIND_TAIL || req_kind == KIND_SECOND)) begin
            mem_we = 1'b1;
            if (req_kind == KIND_SECOND && !is_empty) begin
                mem_waddr = front_dec;
                mem_wdata = r_front_handle;
            end
        end
    end

    qsp_store #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (HANDLE_BITS),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (front_inc),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_front     <= '0;
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            if (r_rsp_valid && !i_rsp_stall) begin
                r_rsp_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        // Default result reports the queue as it stands.
                        r_rsp_popped_valid  <= 1'b0;
                        r_rsp_popped_handle <= '0;
                        r_rsp_dropped       <= 1'b0;
                        r_rsp_front_valid   <= !is_empty;
                        r_rsp_front_handle  <= is_empty ? '0 : r_front_handle;
                        r_rsp_is_empty      <= is_empty;
                        r_rsp_occupancy     <= r_count;
                        r_rsp_valid         <= 1'b1;
                        unique case (req_kind) inside
                            KIND_TAIL, KIND_SECOND: begin
                                if (is_full) begin
                                    r_rsp_dropped <= 1'b1;
                                end else if (req_kind == KIND_SECOND && !is_empty) begin
                                    r_front      <= front_dec;
                                    r_count      <= r_count + CW'(1);
                                    r_ins_addr   <= r_front;
                                    r_ins_handle <= i_req_handle;
                                    r_rsp_valid  <= 1'b0;
                                    r_state      <= ST_INS_WRITE;
                                end else begin
                                    r_count           <= r_count + CW'(1);
                                    r_rsp_front_valid <= 1'b1;
                                    r_rsp_is_empty    <= 1'b0;
                                    r_rsp_occupancy   <= r_count + CW'(1);
                                    if (is_empty) begin
                                        r_front_handle     <= i_req_handle;
                                        r_rsp_front_handle <= i_req_handle;
                                    end
                                end
                            end
                            KIND_POP: begin
                                if (!is_empty) begin
                                    r_front             <= front_inc;
                                    r_count             <= r_count - CW'(1);
                                    r_rsp_popped_valid  <= 1'b1;
                                    r_rsp_popped_handle <= r_front_handle;
                                    r_rsp_occupancy     <= r_count - CW'(1);
                                    if (r_count == CW'(1)) begin
                                        r_rsp_front_valid  <= 1'b0;
                                        r_rsp_front_handle <= '0;
                                        r_rsp_is_empty     <= 1'b1;
                                    end else begin
                                        // The new front arrives from the store next cycle.
                                        r_rsp_valid <= 1'b0;
                                        r_state     <= ST_POP_READ;
                                    end
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_POP_READ: begin
                    r_front_handle     <= mem_rdata;
                    r_rsp_front_handle <= mem_rdata;
                    r_rsp_front_valid  <= 1'b1;
                    r_rsp_is_empty     <= 1'b0;
                    r_rsp_valid        <= 1'b1;
                    r_state            <= ST_IDLE;
                end
                ST_INS_WRITE: begin
                    r_rsp_popped_valid  <= 1'b0;
                    r_rsp_popped_handle <= '0;
                    r_rsp_dropped       <= 1'b0;
                    r_rsp_front_valid   <= 1'b1;
                    r_rsp_front_handle  <= r_front_handle;
                    r_rsp_is_empty      <= 1'b0;
                    r_rsp_occupancy     <= r_count;
                    r_rsp_valid         <= 1'b1;
                    r_state             <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_rsp_valid         = r_rsp_valid;
    assign o_rsp_popped_valid  = r_rsp_popped_valid;
    assign o_rsp_popped_handle = r_rsp_popped_handle;
    assign o_rsp_front_valid   = r_rsp_front_valid;
    assign o_rsp_front_handle  = r_rsp_front_handle;
    assign o_rsp_is_empty      = r_rsp_is_empty;
    assign o_rsp_occupancy     = r_rsp_occupancy;
    assign o_rsp_dropped       = r_rsp_dropped;

endmodule

// ===== src/qsp_checker.sv =====
module qsp_checker
    import qsp_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int HANDLE_BITS = 16
) (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_req_valid,
    input logic                               o_req_stall,
    input logic [1:0]                         i_req_kind,
    input logic [HANDLE_BITS-1:0]             i_req_handle,
    input logic                               o_rsp_valid,
    input logic                               i_rsp_stall,
    input logic                               o_rsp_popped_valid,
    input logic [HANDLE_BITS-1:0]             o_rsp_popped_handle,
    input logic                               o_rsp_front_valid,
    input logic [HANDLE_BITS-1:0]             o_rsp_front_handle,
    input logic                               o_rsp_is_empty,
    input logic [$clog2(QUEUE_DEPTH + 1)-1:0] o_rsp_occupancy,
    input logic                               o_rsp_dropped
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    // Requests are handled one at a time, so a shown result belongs to the
    // most recently accepted request.
    logic [1:0] r_last_kind;

    always_ff @(posedge i_clk) begin
        if (i_req_valid && !o_req_stall) begin
            r_last_kind <= i_req_kind;
        end
    end

    a_occupancy_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> o_rsp_occupancy <= CW'(QUEUE_DEPTH))
        else $error("occupancy above queue depth");

    a_flags_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> (o_rsp_is_empty == (o_rsp_occupancy == '0)) &&
                        (o_rsp_front_valid == !o_rsp_is_empty))
        else $error("empty, front and occupancy disagree");

    a_pop_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_rsp_popped_valid |->
            r_last_kind == KIND_POP && !o_rsp_dropped)
        else $error("popped item reported for a request that was not a pop");

    a_drop_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_rsp_dropped |->
            o_rsp_occupancy == CW'(QUEUE_DEPTH) &&
            (r_last_kind == KIND_TAIL || r_last_kind == KIND_SECOND))
        else $error("push dropped while queue not full");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && i_rsp_stall |=>
            o_rsp_valid && $stable(o_rsp_popped_handle) && $stable(o_rsp_front_handle))
        else $error("stalled result changed");

endmodule

bind queue_with_second_place_insert_unit qsp_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .HANDLE_BITS (HANDLE_BITS)
) u_qsp_checker (.*);
